@@ design/omi_pkg.sv @@
package omi_pkg;

	localparam int unsigned ANG_W = 23;                 // working width for angle sums
	localparam logic signed [ANG_W-1:0] PI_Q      = 23'sd205887;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q  = 23'sd411774;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q = 23'sd102944;
	localparam logic signed [27:0]      PI_Q24    = 28'sd52707179;
	localparam logic [22:0]             CORDIC_K23 = 23'd5094007;

	localparam int unsigned CX_W = 44;                  // cordic x/y datapath
	localparam int unsigned CZ_W = 28;                  // cordic angle accumulator Q4.24

	localparam logic [1:0] REG_ROT_GAIN   = 2'd0;
	localparam logic [1:0] REG_TRANS_GAIN = 2'd1;
	localparam logic [1:0] REG_THRESHOLD  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_MAG_LO,
		ST_MAG_HI,
		ST_ROT,
		ST_DEV1,
		ST_DEV2,
		ST_DEV3,
		ST_DONE
	} omi_state_t;

	// atan(2^-i) in Q0.24
	function automatic logic [23:0] atan_q24(input logic [4:0] idx);
		logic [23:0] v;
		begin
			case (idx)
				5'd0:  v = 24'd13176795;
				5'd1:  v = 24'd7778716;
				5'd2:  v = 24'd4110060;
				5'd3:  v = 24'd2086331;
				5'd4:  v = 24'd1047214;
				5'd5:  v = 24'd524117;
				5'd6:  v = 24'd262123;
				5'd7:  v = 24'd131069;
				5'd8:  v = 24'd65536;
				5'd9:  v = 24'd32768;
				5'd10: v = 24'd16384;
				5'd11: v = 24'd8192;
				5'd12: v = 24'd4096;
				5'd13: v = 24'd2048;
				5'd14: v = 24'd1024;
				5'd15: v = 24'd512;
				5'd16: v = 24'd256;
				5'd17: v = 24'd128;
				5'd18: v = 24'd64;
				5'd19: v = 24'd32;
				5'd20: v = 24'd16;
				5'd21: v = 24'd8;
				5'd22: v = 24'd4;
				5'd23: v = 24'd2;
				5'd24: v = 24'd1;
				default: v = 24'd0;
			endcase
			return v;
		end
	endfunction

	// one wrap step into [-pi, pi], enough for all sums in this block
	function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [ANG_W-1:0] d);
		logic signed [ANG_W-1:0] r;
		begin
			if (d > PI_Q)
				r = d - TWO_PI_Q;
			else if (d < -PI_Q)
				r = d + TWO_PI_Q;
			else
				r = d;
			return r;
		end
	endfunction

endpackage

@@ design/omi_mul.sv @@
module omi_mul import omi_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [23:0] b,
	output logic [55:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= 56'(a) * 56'(b);
	end

endmodule

@@ design/omi_cordic.sv @@
module omi_cordic import omi_pkg::*; #(
	parameter int CORDIC_STEPS = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [32:0]     dx,
	input  logic signed [32:0]     dy,
	output logic                   done,
	output logic signed [20:0]     angle,
	output logic [CX_W-1:0]        xmag
);

	localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

	logic                   busy_q;
	logic [ITER_W-1:0]      iter_q;
	logic signed [CX_W-1:0] x_q, y_q;
	logic signed [CZ_W-1:0] z_q;
	logic                   zero_q;

	logic signed [CX_W-1:0] x0, y0, xs, ys;
	logic signed [CZ_W-1:0] at;
	logic signed [CZ_W-1:0] zr;

	always_comb begin
		x0 = {{(CX_W-41){dx[32]}}, dx, 8'd0};
		y0 = {{(CX_W-41){dy[32]}}, dy, 8'd0};
		xs = x_q >>> iter_q;
		ys = y_q >>> iter_q;
		at = CZ_W'(atan_q24(5'(iter_q)));
		zr = z_q + CZ_W'(128);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iter_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				if (iter_q == LAST_ITER) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (dx == '0) && (dy == '0);
			if (dx < 0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= (dy >= 0) ? PI_Q24 : -PI_Q24;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign angle = zero_q ? '0 : 21'(zr >>> 8);
	assign xmag  = zero_q ? '0 : x_q;

endmodule

@@ design/odometry_motion_increment_core.sv @@
// channel   direction  handshake            payload
// in        sink       in_valid/in_stall    x_position, y_position, heading
// out       source     out_valid/out_stall  rotations, translation, moved, deviations
// cfg       sink       apb write/read       rotation_gain, translation_gain, motion_threshold
//
// a pose runs from accept through ST_CORDIC, ST_MAG_LO, ST_MAG_HI, ST_ROT, ST_DEV1 to
// ST_DEV3 and ST_DONE, which waits for room in the output register; the next pose
// is taken back in idle; the vectoring cordic loop runs one iteration a cycle
// a shared 32x24 multiplier does the magnitude scaling and the three deviations
// arst_n clears the pose history, the registers to their defaults and all control
// a finished beat waits in the output register while the next pose is taken;
// in_stall is high from accept until the block is back in idle
module odometry_motion_increment_core import omi_pkg::*; #(
	parameter int CORDIC_STEPS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] x_position,
	input  logic signed [31:0] y_position,
	input  logic signed [18:0] heading,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [18:0] first_rotation,
	output logic signed [31:0] signed_translation,
	output logic signed [18:0] second_rotation,
	output logic               moved,
	output logic [17:0]        first_rotation_dev,
	output logic [30:0]        translation_dev,
	output logic [17:0]        second_rotation_dev,
	// config port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	omi_state_t state_q, state_d;

	// config registers
	logic [15:0] rot_gain_q, trans_gain_q, thresh_q;

	// pose history
	logic signed [31:0] last_x_q, last_y_q;
	logic signed [18:0] last_h_q;
	logic               have_prev_q;

	// per-beat working registers
	logic signed [ANG_W-1:0] dh_q;
	logic signed [18:0]      prev_h_q;
	logic                    moved_q;
	logic [63:0]             acc_q;
	logic signed [ANG_W-1:0] rot1_q, rot2_q;
	logic [31:0]             mag_q;
	logic                    rev_q;
	logic [17:0]             dev1_q;
	logic [30:0]             devt_q;

	// output register
	logic               out_valid_q;
	logic signed [18:0] o_rot1_q, o_rot2_q;
	logic signed [31:0] o_trans_q;
	logic               o_moved_q;
	logic [17:0]        o_dev1_q, o_dev2_q;
	logic [30:0]        o_devt_q;

	// cordic
	logic              cordic_start, cordic_done;
	logic signed [20:0] cordic_angle;
	logic [CX_W-1:0]    cordic_x;

	// shared multiplier
	logic [31:0] mul_a;
	logic [23:0] mul_b;
	logic [55:0] prod_q;

	logic        in_acc, out_acc, cfg_wr;
	logic        out_free;
	logic signed [31:0] px, py;
	logic signed [18:0] ph;
	logic signed [32:0] dx_c, dy_c;
	logic signed [ANG_W-1:0] dh_c;
	logic [33:0] adx, ady;
	logic [ANG_W-1:0] adh;

	// rotation stage combinational values
	logic [63:0]             acc_full;
	logic [32:0]             m_hi;
	logic [31:0]             mag_c;
	logic signed [ANG_W-1:0] r1_raw, r1_c, r2_c;
	logic                    rev_c;
	logic [ANG_W-1:0]        abs_r1, abs_r2;
	logic [55:0]             rnd;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;

	// config write and readback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_gain_q   <= 16'd52429;
			trans_gain_q <= 16'd22938;
			thresh_q     <= 16'd7;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ROT_GAIN:   rot_gain_q   <= pwdata[15:0];
				REG_TRANS_GAIN: trans_gain_q <= pwdata[15:0];
				REG_THRESHOLD:  thresh_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ROT_GAIN:   prdata = {16'd0, rot_gain_q};
			REG_TRANS_GAIN: prdata = {16'd0, trans_gain_q};
			REG_THRESHOLD:  prdata = {16'd0, thresh_q};
			default:        prdata = '0;
		endcase
	end

	// deltas against the previous pose; the first pose compares with itself
	always_comb begin
		px   = have_prev_q ? last_x_q : x_position;
		py   = have_prev_q ? last_y_q : y_position;
		ph   = have_prev_q ? last_h_q : heading;
		dx_c = 33'(x_position) - 33'(px);
		dy_c = 33'(y_position) - 33'(py);
		dh_c = wrap_angle(ANG_W'(heading) - ANG_W'(ph));
		adx  = dx_c[32] ? 34'(-34'(dx_c)) : 34'(dx_c);
		ady  = dy_c[32] ? 34'(-34'(dy_c)) : 34'(dy_c);
		adh  = dh_c[ANG_W-1] ? ANG_W'(-dh_c) : ANG_W'(dh_c);
	end

	assign cordic_start = in_acc;

	omi_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cordic_start),
		.dx    (dx_c),
		.dy    (dy_c),
		.done  (cordic_done),
		.angle (cordic_angle),
		.xmag  (cordic_x)
	);

	// magnitude finish, first rotation with reversal, second rotation
	always_comb begin
		acc_full = acc_q + {prod_q[43:0], 20'd0};
		m_hi     = acc_full[63:31];
		if (cordic_x[CX_W-1:40] != '0 || m_hi > 33'h07FFFFFFF)
			mag_c = 32'h7FFFFFFF;
		else
			mag_c = m_hi[31:0];
		r1_raw = wrap_angle(ANG_W'(cordic_angle) - ANG_W'(prev_h_q));
		rev_c  = 1'b0;
		if (mag_c < {16'd0, thresh_q}) begin
			r1_c = '0;
		end else if (r1_raw > HALF_PI_Q) begin
			r1_c  = r1_raw - PI_Q;
			rev_c = 1'b1;
		end else if (r1_raw < -HALF_PI_Q) begin
			r1_c  = r1_raw + PI_Q;
			rev_c = 1'b1;
		end else begin
			r1_c = r1_raw;
		end
		r2_c   = wrap_angle(dh_q - r1_c);
		abs_r1 = rot1_q[ANG_W-1] ? ANG_W'(-rot1_q) : ANG_W'(rot1_q);
		abs_r2 = rot2_q[ANG_W-1] ? ANG_W'(-rot2_q) : ANG_W'(rot2_q);
		rnd    = prod_q + 56'd32768;
	end

	// multiplier operand select; the second rotation product is held while done waits
	always_comb begin
		case (state_q)
			ST_MAG_LO: begin
				mul_a = {12'd0, cordic_x[19:0]};
				mul_b = {1'b0, CORDIC_K23};
			end
			ST_MAG_HI: begin
				mul_a = {12'd0, cordic_x[39:20]};
				mul_b = {1'b0, CORDIC_K23};
			end
			ST_DEV1: begin
				mul_a = 32'(abs_r1);
				mul_b = {8'd0, rot_gain_q};
			end
			ST_DEV2: begin
				mul_a = mag_q;
				mul_b = {8'd0, trans_gain_q};
			end
			ST_DEV3, ST_DONE: begin
				mul_a = 32'(abs_r2);
				mul_b = {8'd0, rot_gain_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	omi_mul u_mul (
		.clk   (clk),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_acc) state_d = ST_CORDIC;
			ST_CORDIC: if (cordic_done) state_d = ST_MAG_LO;
			ST_MAG_LO: state_d = ST_MAG_HI;
			ST_MAG_HI: state_d = ST_ROT;
			ST_ROT:    state_d = ST_DEV1;
			ST_DEV1:   state_d = ST_DEV2;
			ST_DEV2:   state_d = ST_DEV3;
			ST_DEV3:   state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// pose history and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q    <= '0;
			last_y_q    <= '0;
			last_h_q    <= '0;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				last_x_q    <= x_position;
				last_y_q    <= y_position;
				last_h_q    <= heading;
				have_prev_q <= 1'b1;
			end
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_acc)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dh_q     <= dh_c;
			prev_h_q <= ph;
			moved_q  <= (adx > 34'(thresh_q)) || (ady > 34'(thresh_q)) ||
			            (adh > ANG_W'(thresh_q));
		end
		case (state_q)
			ST_MAG_HI: acc_q <= 64'(prod_q) + 64'h40000000;
			ST_ROT: begin
				mag_q  <= mag_c;
				rot1_q <= r1_c;
				rot2_q <= r2_c;
				rev_q  <= rev_c;
			end
			ST_DEV2: dev1_q <= rnd[33:16];
			ST_DEV3: devt_q <= rnd[46:16];
			ST_DONE: begin
				if (out_free) begin
					o_rot1_q  <= rot1_q[18:0];
					o_rot2_q  <= rot2_q[18:0];
					o_trans_q <= rev_q ? -$signed(mag_q) : $signed(mag_q);
					o_moved_q <= moved_q;
					o_dev1_q  <= dev1_q;
					o_devt_q  <= devt_q;
					o_dev2_q  <= rnd[33:16];
				end
			end
			default: ;
		endcase
	end

	assign out_valid           = out_valid_q;
	assign first_rotation      = o_rot1_q;
	assign signed_translation  = o_trans_q;
	assign second_rotation     = o_rot2_q;
	assign moved               = o_moved_q;
	assign first_rotation_dev  = o_dev1_q;
	assign translation_dev     = o_devt_q;
	assign second_rotation_dev = o_dev2_q;

endmodule
